FILE: rtl/core/cascaded_position_velocity_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the position/velocity controller
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CASCADED_POSITION_VELOCITY_CONTROLLER_MACROS_SVH
`define CASCADED_POSITION_VELOCITY_CONTROLLER_MACROS_SVH

// same-cycle implication
`define CPVC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPVC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cpvc_pkg.sv
// ----------------------------------------------------------------------------
// cpvc_pkg
// Shared types, constants and helpers of the position/velocity controller.
// ----------------------------------------------------------------------------
package cpvc_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int DIR_FRAC_BITS = 14;
    localparam int SQRT_STEPS    = 32;
    localparam int DIV_STEPS     = 64;

    localparam logic [1:0]  AXIS_X  = 2'd0;
    localparam logic [1:0]  AXIS_Y  = 2'd1;
    localparam logic [1:0]  AXIS_Z  = 2'd2;
    localparam logic [30:0] ACC_MAX = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        CFG_POS_GAIN    = 3'd0,
        CFG_MAX_SPEED   = 3'd1,
        CFG_VEL_P_GAIN  = 3'd2,
        CFG_VEL_I_GAIN  = 3'd3,
        CFG_INT_STEP    = 3'd4,
        CFG_INT_LIMIT   = 3'd5,
        CFG_GRAVITY     = 3'd6,
        CFG_MAX_LATERAL = 3'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_LD_PERR,
        OP_LD_VERR,
        OP_LD_INT,
        OP_LD_ACC,
        OP_LD_ML,
        OP_MUL_POS,
        OP_MUL_STEP,
        OP_MUL_VP,
        OP_MUL_VI,
        OP_MUL_ML,
        OP_MUL_SELF,
        OP_VREF,
        OP_INTEG,
        OP_SAVE,
        OP_ACC,
        OP_SQ_ADD,
        OP_LAT_CMP,
        OP_SQRT_GO,
        OP_DIV_PROD,
        OP_DIV_DIR,
        OP_SCALE,
        OP_DIR,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic lat_big;
        logic sqrt_busy;
        logic div_busy;
    } sts_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_PERR, ST_MPOS, ST_VREF, ST_VERR, ST_MSTEP, ST_INTEG,
        ST_MVP, ST_SAVE, ST_LDINT, ST_MVI, ST_ACC,
        ST_LLD, ST_LMUL, ST_LADD, ST_MLLD, ST_MLMUL, ST_LCMP, ST_LSQ, ST_LSQW,
        ST_SLD, ST_SMUL, ST_SDIV, ST_SDIVW, ST_SSTORE,
        ST_NLD, ST_NMUL, ST_NADD, ST_NSQ, ST_NSQW,
        ST_DLD, ST_DDIV, ST_DDIVW, ST_DSTORE,
        ST_PUB
    } st_t;

    function automatic logic signed [63:0] clamp_sym(input logic signed [63:0] v,
                                                     input logic [30:0] lim);
        logic signed [63:0] l;
        l = signed'(64'(lim));
        if (v > l)
        begin
            return l;
        end
        if (v < -l)
        begin
            return -l;
        end
        return v;
    endfunction

endpackage

FILE: rtl/core/cpvc_sqrt.sv
// ----------------------------------------------------------------------------
// cpvc_sqrt
// Bit-serial integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cpvc_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] x,
    output logic        busy,
    output logic [31:0] root
);
    import cpvc_pkg::*;

    localparam int CW = $clog2(SQRT_STEPS);

    logic [63:0]   x_reg;
    logic [33:0]   rem_reg;
    logic [31:0]   root_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [33:0]   rem_sh;
    logic [33:0]   trial;
    logic          ge;

    assign rem_sh = {rem_reg[31:0], x_reg[63:62]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            x_reg    <= x_reg << 2;
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[30:0], ge};
            cnt_reg  <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(SQRT_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

FILE: rtl/core/cpvc_div.sv
// ----------------------------------------------------------------------------
// cpvc_div
// Restoring bit-serial divider, 64-bit dividend by 32-bit divisor.
// ----------------------------------------------------------------------------
module cpvc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [63:0] quot
);
    import cpvc_pkg::*;

    localparam int CW = $clog2(DIV_STEPS);

    logic [63:0]   q_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [32:0]   rem_sh;
    logic [32:0]   diff;
    logic          ge;

    assign rem_sh = {rem_reg, q_reg[63]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            q_reg    <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[31:0] : rem_sh[31:0];
            q_reg   <= {q_reg[62:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

FILE: rtl/core/cpvc_dp.sv
// ----------------------------------------------------------------------------
// cpvc_dp
// Datapath: configuration registers, shared multiplier, integrators,
// square-root and divider units, result register.
// ----------------------------------------------------------------------------
module cpvc_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  cpvc_pkg::cmd_t  cmd,
    output cpvc_pkg::sts_t  sts,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    input  logic [287:0]    in_data,
    output logic [143:0]    out_data,
    output logic            out_zero
);
    import cpvc_pkg::*;

    logic [30:0] pos_gain_reg, max_speed_reg, vel_p_gain_reg, vel_i_gain_reg;
    logic [16:0] int_step_reg;
    logic [30:0] int_limit_reg, gravity_reg, max_lateral_reg;

    logic signed [31:0] tgt_reg   [0:2];
    logic signed [31:0] pos_reg   [0:2];
    logic signed [31:0] vel_reg   [0:2];
    logic signed [31:0] vref_reg  [0:2];
    logic signed [31:0] integ_reg [0:2];
    logic signed [31:0] acc_reg   [0:2];
    logic        [15:0] dir_reg   [0:2];

    logic signed [63:0] acc_tmp_reg;
    logic        [32:0] opa_mag_reg;
    logic               opa_neg_reg;
    logic        [63:0] prod_reg;
    logic        [63:0] sum_reg;
    logic               lat_big_reg;
    logic       [143:0] out_data_reg;
    logic               out_zero_reg;

    logic [1:0]         ax;
    logic signed [33:0] ld_val;
    logic [33:0]        ld_abs;
    logic [30:0]        mul_b;
    logic [63:0]        mul_p;
    logic [63:0]        q_mag;
    logic signed [63:0] q;
    logic signed [63:0] integ_sum;
    logic signed [63:0] acc_sum;
    logic signed [63:0] grav_sub;
    logic [63:0]        div_dividend;
    logic               sqrt_start, div_start, sqrt_busy, div_busy;
    logic [31:0]        root;
    logic [63:0]        quot;
    logic               zero;

    assign ax = cmd.axis;

    always_comb
    begin
        unique case (cmd.op)
            OP_LD_PERR: ld_val = 34'(tgt_reg[ax]) - 34'(pos_reg[ax]);
            OP_LD_VERR: ld_val = 34'(vref_reg[ax]) - 34'(vel_reg[ax]);
            OP_LD_INT:  ld_val = 34'(integ_reg[ax]);
            OP_LD_ACC:  ld_val = 34'(acc_reg[ax]);
            OP_LD_ML:   ld_val = signed'({3'b000, max_lateral_reg});
            default:    ld_val = '0;
        endcase
    end

    assign ld_abs = ld_val[33] ? 34'(-ld_val) : 34'(ld_val);

    always_comb
    begin
        unique case (cmd.op)
            OP_MUL_POS:  mul_b = pos_gain_reg;
            OP_MUL_STEP: mul_b = 31'(int_step_reg);
            OP_MUL_VP:   mul_b = vel_p_gain_reg;
            OP_MUL_VI:   mul_b = vel_i_gain_reg;
            OP_MUL_ML:   mul_b = max_lateral_reg;
            OP_MUL_SELF: mul_b = opa_mag_reg[30:0];
            default:     mul_b = '0;
        endcase
    end

    assign mul_p     = 64'(opa_mag_reg) * 64'(mul_b);
    assign q_mag     = prod_reg >> FRAC_BITS;
    assign q         = opa_neg_reg ? -signed'(q_mag) : signed'(q_mag);
    assign integ_sum = 64'(integ_reg[ax]) + q;
    assign grav_sub  = (ax == AXIS_Z) ? signed'(64'(gravity_reg)) : 64'sd0;
    assign acc_sum   = acc_tmp_reg + q - grav_sub;

    assign sqrt_start   = cmd.op == OP_SQRT_GO;
    assign div_start    = (cmd.op == OP_DIV_PROD) || (cmd.op == OP_DIV_DIR);
    assign div_dividend = (cmd.op == OP_DIV_PROD) ? prod_reg
                                                  : (64'(opa_mag_reg) << DIR_FRAC_BITS);
    assign zero         = root == '0;

    cpvc_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (sum_reg),
        .busy  (sqrt_busy),
        .root  (root)
    );

    cpvc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (root),
        .busy     (div_busy),
        .quot     (quot)
    );

    // configuration and integrator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_gain_reg    <= 31'd65536;
            max_speed_reg   <= 31'd327680;
            vel_p_gain_reg  <= 31'd65536;
            vel_i_gain_reg  <= '0;
            int_step_reg    <= 17'd655;
            int_limit_reg   <= 31'd65536;
            gravity_reg     <= 31'd642908;
            max_lateral_reg <= 31'd642908;
            for (int i = 0; i < 3; i++)
            begin
                integ_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_POS_GAIN:    pos_gain_reg    <= cfg_data[30:0];
                    CFG_MAX_SPEED:   max_speed_reg   <= cfg_data[30:0];
                    CFG_VEL_P_GAIN:  vel_p_gain_reg  <= cfg_data[30:0];
                    CFG_VEL_I_GAIN:  vel_i_gain_reg  <= cfg_data[30:0];
                    CFG_INT_STEP:    int_step_reg    <= cfg_data[16:0];
                    CFG_INT_LIMIT:   int_limit_reg   <= cfg_data[30:0];
                    CFG_GRAVITY:     gravity_reg     <= cfg_data[30:0];
                    CFG_MAX_LATERAL: max_lateral_reg <= cfg_data[30:0];
                    default:         ;
                endcase
            end
            if (cmd.op == OP_INTEG)
            begin
                integ_reg[ax] <= 32'(clamp_sym(integ_sum, int_limit_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op) inside
            OP_CAPTURE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    tgt_reg[i] <= in_data[32*i +: 32];
                    pos_reg[i] <= in_data[96 + 32*i +: 32];
                    vel_reg[i] <= in_data[192 + 32*i +: 32];
                end
            end
            OP_LD_PERR, OP_LD_VERR, OP_LD_INT, OP_LD_ACC, OP_LD_ML:
            begin
                opa_mag_reg <= ld_abs[32:0];
                opa_neg_reg <= ld_val[33];
            end
            OP_MUL_POS, OP_MUL_STEP, OP_MUL_VP, OP_MUL_VI, OP_MUL_ML, OP_MUL_SELF:
            begin
                prod_reg <= mul_p;
            end
            OP_VREF:     vref_reg[ax] <= 32'(clamp_sym(q, max_speed_reg));
            OP_SAVE:     acc_tmp_reg  <= q;
            OP_ACC:      acc_reg[ax]  <= 32'(clamp_sym(acc_sum, ACC_MAX));
            OP_SQ_ADD:   sum_reg      <= ((ax == AXIS_X) ? 64'd0 : sum_reg) + prod_reg;
            OP_LAT_CMP:  lat_big_reg  <= sum_reg > prod_reg;
            OP_SCALE:
            begin
                acc_reg[ax] <= opa_neg_reg ? -signed'(quot[31:0]) : signed'(quot[31:0]);
            end
            OP_DIR:
            begin
                dir_reg[ax] <= zero ? 16'd0 : (opa_neg_reg ? -quot[15:0] : quot[15:0]);
            end
            OP_PUBLISH:
            begin
                out_data_reg <= {vref_reg[2], vref_reg[1], vref_reg[0],
                                 dir_reg[2], dir_reg[1], dir_reg[0]};
                out_zero_reg <= zero;
            end
            default: ;
        endcase
    end

    assign sts.lat_big   = lat_big_reg;
    assign sts.sqrt_busy = sqrt_busy;
    assign sts.div_busy  = div_busy;
    assign out_data      = out_data_reg;
    assign out_zero      = out_zero_reg;

endmodule

FILE: rtl/core/cpvc_ctrl.sv
// ----------------------------------------------------------------------------
// cpvc_ctrl
// Sequencer: steps the datapath through one update, handles both handshakes.
// ----------------------------------------------------------------------------
module cpvc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output cpvc_pkg::cmd_t cmd,
    input  cpvc_pkg::sts_t sts
);
    import cpvc_pkg::*;

    st_t        state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.op         = OP_NOP;
        cmd.axis       = axis_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_CAPTURE;
                    axis_next  = AXIS_X;
                    state_next = ST_PERR;
                end
            end
            ST_PERR:  begin cmd.op = OP_LD_PERR;  state_next = ST_MPOS;  end
            ST_MPOS:  begin cmd.op = OP_MUL_POS;  state_next = ST_VREF;  end
            ST_VREF:  begin cmd.op = OP_VREF;     state_next = ST_VERR;  end
            ST_VERR:  begin cmd.op = OP_LD_VERR;  state_next = ST_MSTEP; end
            ST_MSTEP: begin cmd.op = OP_MUL_STEP; state_next = ST_INTEG; end
            ST_INTEG: begin cmd.op = OP_INTEG;    state_next = ST_MVP;   end
            ST_MVP:   begin cmd.op = OP_MUL_VP;   state_next = ST_SAVE;  end
            ST_SAVE:  begin cmd.op = OP_SAVE;     state_next = ST_LDINT; end
            ST_LDINT: begin cmd.op = OP_LD_INT;   state_next = ST_MVI;   end
            ST_MVI:   begin cmd.op = OP_MUL_VI;   state_next = ST_ACC;   end
            ST_ACC:
            begin
                cmd.op = OP_ACC;
                if (axis_reg == AXIS_Z)
                begin
                    axis_next  = AXIS_X;
                    state_next = ST_LLD;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_PERR;
                end
            end
            ST_LLD:   begin cmd.op = OP_LD_ACC;   state_next = ST_LMUL;  end
            ST_LMUL:  begin cmd.op = OP_MUL_SELF; state_next = ST_LADD;  end
            ST_LADD:
            begin
                cmd.op = OP_SQ_ADD;
                if (axis_reg == AXIS_Y)
                begin
                    axis_next  = AXIS_X;
                    state_next = ST_MLLD;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_LLD;
                end
            end
            ST_MLLD:  begin cmd.op = OP_LD_ML;    state_next = ST_MLMUL; end
            ST_MLMUL: begin cmd.op = OP_MUL_SELF; state_next = ST_LCMP;  end
            ST_LCMP:  begin cmd.op = OP_LAT_CMP;  state_next = ST_LSQ;   end
            ST_LSQ:
            begin
                if (sts.lat_big)
                begin
                    cmd.op     = OP_SQRT_GO;
                    state_next = ST_LSQW;
                end
                else
                begin
                    state_next = ST_NLD;
                end
            end
            ST_LSQW:
            begin
                if (!sts.sqrt_busy)
                begin
                    state_next = ST_SLD;
                end
            end
            ST_SLD:   begin cmd.op = OP_LD_ACC;   state_next = ST_SMUL;  end
            ST_SMUL:  begin cmd.op = OP_MUL_ML;   state_next = ST_SDIV;  end
            ST_SDIV:  begin cmd.op = OP_DIV_PROD; state_next = ST_SDIVW; end
            ST_SDIVW:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_SSTORE;
                end
            end
            ST_SSTORE:
            begin
                cmd.op = OP_SCALE;
                if (axis_reg == AXIS_Y)
                begin
                    axis_next  = AXIS_X;
                    state_next = ST_NLD;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_SLD;
                end
            end
            ST_NLD:   begin cmd.op = OP_LD_ACC;   state_next = ST_NMUL;  end
            ST_NMUL:  begin cmd.op = OP_MUL_SELF; state_next = ST_NADD;  end
            ST_NADD:
            begin
                cmd.op = OP_SQ_ADD;
                if (axis_reg == AXIS_Z)
                begin
                    axis_next  = AXIS_X;
                    state_next = ST_NSQ;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_NLD;
                end
            end
            ST_NSQ:   begin cmd.op = OP_SQRT_GO;  state_next = ST_NSQW;  end
            ST_NSQW:
            begin
                if (!sts.sqrt_busy)
                begin
                    state_next = ST_DLD;
                end
            end
            ST_DLD:   begin cmd.op = OP_LD_ACC;   state_next = ST_DDIV;  end
            ST_DDIV:  begin cmd.op = OP_DIV_DIR;  state_next = ST_DDIVW; end
            ST_DDIVW:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_DSTORE;
                end
            end
            ST_DSTORE:
            begin
                cmd.op = OP_DIR;
                if (axis_reg == AXIS_Z)
                begin
                    axis_next  = AXIS_X;
                    state_next = ST_PUB;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_DLD;
                end
            end
            ST_PUB:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.op         = OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;

endmodule

FILE: rtl/core/cascaded_position_velocity_controller.sv
// ----------------------------------------------------------------------------
// cascaded_position_velocity_controller
// Cascaded P position / PI velocity controller giving a thrust direction.
// ----------------------------------------------------------------------------
// Input stream: one transaction per control update carrying target, measured
// position and measured velocity for x, y, z (Q16.16). Output stream: one
// transaction per update with the Q2.14 thrust direction and the clamped
// velocity reference; tuser flags a zero acceleration vector.
// Configuration: write channel, index selects the register, always ready;
// write only while no update is in flight.
// The bit-serial divider (64 steps per quotient) runs three quotients per update,
// five when the lateral limit engages; the square-root unit (32 steps) runs once,
// or twice when the lateral limit engages.
// One update is processed at a time; the next input is taken once the
// current one has reached the output register.
// Reset clears the integrators and loads the default gains and limits.
// If the receiver stalls, the finished result holds in the output register
// and the next update may still run; it waits at the end for the register.
// ----------------------------------------------------------------------------
module cascaded_position_velocity_controller (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // target_x, target_y, target_z, meas_pos_x..z, meas_vel_x..z
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // dir_x, dir_y, dir_z, vel_ref_x, vel_ref_y, vel_ref_z
    output logic [143:0] m_tdata,
    // zero_norm
    output logic         m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import cpvc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    cpvc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    cpvc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .out_data  (m_tdata),
        .out_zero  (m_tuser)
    );

endmodule

FILE: rtl/core/cpvc_checker.sv
// ----------------------------------------------------------------------------
// cpvc_checker
// Port-level assertions for the position/velocity controller.
// ----------------------------------------------------------------------------
`include "cascaded_position_velocity_controller_macros.svh"

module cpvc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic         m_tuser
);

    logic [144:0] m_word;
    logic [47:0]  dir_bits;

    assign m_word   = {m_tuser, m_tdata};
    assign dir_bits = m_tdata[47:0];

    `CPVC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped under stall")
    `CPVC_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_word), "stall changed result")
    `CPVC_ASSERT_NXT(a_busy_after_in, s_tvalid && s_tready, !s_tready, "input taken mid-update")
    `CPVC_ASSERT_IMP(a_zero_dir, m_tvalid && m_tuser, dir_bits == '0, "zero norm, direction set")

endmodule

bind cascaded_position_velocity_controller cpvc_checker u_cpvc_checker (.*);

FILE: tb/sv/cascaded_position_velocity_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position/velocity controller testbench
// Drives control updates through the input stream and checks every output
// transaction against a behavioural model of the P/PI cascade. Register
// settings change between phases, once the block is idle. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module cascaded_position_velocity_controller_test;
    import cpvc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 1850;

    typedef struct packed {
        logic        zn;
        logic [31:0] vz;
        logic [31:0] vy;
        logic [31:0] vx;
        logic [15:0] dz;
        logic [15:0] dy;
        logic [15:0] dx;
    } ctrl_out_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    logic [63:0]  gain_reg [8];
    logic signed [63:0] integ [3];
    ctrl_out_t    pending_q [$];
    int           errors = 0;
    int           n_out = 0;
    int           n_zero = 0;
    int           idle_cycles = 0;
    logic         rx_run = 1'b1;

    cascaded_position_velocity_controller u_top (.*);

    always #2 clk = ~clk;

    function automatic logic signed [63:0] sat_sym(logic signed [63:0] v,
                                                   logic signed [63:0] lim);
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] gain_mul(logic signed [63:0] a, logic [63:0] g);
        logic [63:0] m;
        m = a < 0 ? -a : a;
        m = (m * g) >> FRAC_BITS;
        return a < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [63:0] ratio(logic signed [63:0] a, logic [63:0] num,
                                                 logic [63:0] den);
        logic [63:0] q;
        q = (mag(a) * num) / den;
        return a < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic ctrl_out_t predict_update(logic [287:0] d);
        logic signed [63:0] vref [3];
        logic signed [63:0] acc [3];
        logic signed [63:0] perr;
        logic signed [63:0] verr;
        logic signed [63:0] a;
        logic [63:0] lsq;
        logic [63:0] nrm;
        logic [63:0] q;
        logic signed [63:0] dv [3];
        ctrl_out_t r;
        for (int i = 0; i < 3; i++)
        begin
            perr = 64'($signed(d[32*i +: 32])) - 64'($signed(d[32*(3+i) +: 32]));
            vref[i] = sat_sym(gain_mul(perr, gain_reg[CFG_POS_GAIN]),
                              $signed(gain_reg[CFG_MAX_SPEED]));
            verr = vref[i] - 64'($signed(d[32*(6+i) +: 32]));
            integ[i] = sat_sym(integ[i] + gain_mul(verr, gain_reg[CFG_INT_STEP]),
                               $signed(gain_reg[CFG_INT_LIMIT]));
            a = gain_mul(verr, gain_reg[CFG_VEL_P_GAIN])
              + gain_mul(integ[i], gain_reg[CFG_VEL_I_GAIN]);
            if (i == 2)
            begin
                a = a - $signed(gain_reg[CFG_GRAVITY]);
            end
            acc[i] = sat_sym(a, 64'sd2147483647);
        end
        lsq = mag(acc[0]) * mag(acc[0]) + mag(acc[1]) * mag(acc[1]);
        if (lsq > gain_reg[CFG_MAX_LATERAL] * gain_reg[CFG_MAX_LATERAL])
        begin
            nrm = root64(lsq);
            acc[0] = ratio(acc[0], gain_reg[CFG_MAX_LATERAL], nrm);
            acc[1] = ratio(acc[1], gain_reg[CFG_MAX_LATERAL], nrm);
        end
        nrm = root64(mag(acc[0]) * mag(acc[0]) + mag(acc[1]) * mag(acc[1])
                     + mag(acc[2]) * mag(acc[2]));
        for (int i = 0; i < 3; i++)
        begin
            dv[i] = 0;
            if (nrm != 0)
            begin
                q = (mag(acc[i]) << DIR_FRAC_BITS) / nrm;
                dv[i] = acc[i] < 0 ? -$signed(q) : $signed(q);
            end
        end
        r.dx = dv[0][15:0];
        r.dy = dv[1][15:0];
        r.dz = dv[2][15:0];
        r.vx = vref[0][31:0];
        r.vy = vref[1][31:0];
        r.vz = vref[2][31:0];
        r.zn = (nrm == 0);
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
    endfunction

    function automatic void check_field(string name, logic [31:0] e, logic [31:0] g);
        if (g !== e)
        begin
            $error("%s expected %h actual %h", name, e, g);
            errors++;
        end
    endfunction

    // receiver side: random stalls, checks every output transaction
    always @(posedge clk)
    begin
        ctrl_out_t got;
        ctrl_out_t exp_r;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata};
                n_out++;
                if (got.zn)
                begin
                    n_zero++;
                end
                if (pending_q.size() == 0)
                begin
                    $error("unexpected output transaction");
                    errors++;
                end
                else
                begin
                    exp_r = pending_q.pop_front();
                    check_field("dir_x", 32'(exp_r.dx), 32'(got.dx));
                    check_field("dir_y", 32'(exp_r.dy), 32'(got.dy));
                    check_field("dir_z", 32'(exp_r.dz), 32'(got.dz));
                    check_field("vel_ref_x", exp_r.vx, got.vx);
                    check_field("vel_ref_y", exp_r.vy, got.vy);
                    check_field("vel_ref_z", exp_r.vz, got.vz);
                    check_field("zero_norm", 32'(exp_r.zn), 32'(got.zn));
                end
            end
            m_tready <= rx_run ? ($urandom_range(0, 3) != 0) : 1'b1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // cfg_valid is left high between back-to-back writes and dropped by
    // the next update
    task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        gain_reg[idx] = (idx == CFG_INT_STEP) ? 64'(v[16:0]) : 64'(v[30:0]);
    endtask

    // s_tvalid is left high after the transaction while the block is busy;
    // drain drops it, and the next call drops it or drives new data
    task automatic send_update(logic [287:0] d);
        int g;
        g = gap_len();
        cfg_valid <= 1'b0;
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pending_q.push_back(predict_update(d));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1310720)) - 655360);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 65536 * 8)) - 65536 * 4);
        endcase
    endfunction

    function automatic logic [287:0] rand_update();
        logic [287:0] d;
        logic [31:0] base;
        base = rand_word();
        for (int i = 0; i < 9; i++)
        begin
            d[32*i +: 32] = ($urandom_range(0, 3) == 0) ? base : rand_word();
        end
        return d;
    endfunction

    task automatic random_settings(bit extreme);
        logic [31:0] v;
        for (int i = 0; i < 8; i++)
        begin
            if (extreme)
            begin
                v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ((i == CFG_MAX_LATERAL) ? 1 : 0);
            end
            else
            begin
                v = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 65536 * 16);
            end
            write_reg(cfg_idx_t'(i), v);
        end
    endtask

    logic [287:0] dir_stim [14];
    ctrl_out_t    dir_exp  [14];
    bit           dir_known [14];

    initial
    begin
        gain_reg[CFG_POS_GAIN]    = 65536;
        gain_reg[CFG_MAX_SPEED]   = 327680;
        gain_reg[CFG_VEL_P_GAIN]  = 65536;
        gain_reg[CFG_VEL_I_GAIN]  = 0;
        gain_reg[CFG_INT_STEP]    = 655;
        gain_reg[CFG_INT_LIMIT]   = 65536;
        gain_reg[CFG_GRAVITY]     = 642908;
        gain_reg[CFG_MAX_LATERAL] = 642908;
        for (int i = 0; i < 3; i++)
        begin
            integ[i] = 0;
        end
        // all zero after reset: straight up, vel_ref zero
        dir_stim[0] = '0;
        dir_exp[0]  = '{zn: 1'b0, vz: 0, vy: 0, vx: 0, dz: 16'hC000, dy: 0, dx: 0};
        dir_known[0] = 1;
        dir_stim[1] = {9{32'h7FFF_FFFF}};
        dir_stim[2] = {9{32'h8000_0000}};
        dir_stim[3] = {96'h0, {3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}};
        dir_stim[4] = {96'h0, {3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}};
        dir_stim[5] = {32'h0, 32'h0, 32'h0, 96'h0, 32'h0, 32'h0, 32'h000A_0000};
        dir_stim[6] = {32'h0, 32'h0, 32'h0, 96'h0, 32'h0, 32'hFFF6_0000, 32'h000A_0000};
        dir_stim[7] = {32'h0, 32'h0, 32'hFFF0_0000, 96'h0, 96'h0};
        dir_stim[8] = {32'h000F_0000, 32'h0, 32'h0, 96'h0, 96'h0};
        for (int i = 9; i < 14; i++)
        begin
            dir_stim[i] = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom(), $urandom()};
        end
        for (int i = 1; i < 14; i++)
        begin
            dir_known[i] = 0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 14; i++)
        begin
            send_update(dir_stim[i]);
            if (dir_known[i] && pending_q[$] !== dir_exp[i])
            begin
                $error("directed row %0d: model disagrees with table", i);
                errors++;
            end
        end
        drain();

        // zero norm: no gravity, zero velocity gains
        write_reg(CFG_GRAVITY, 0);
        write_reg(CFG_VEL_P_GAIN, 0);
        send_update('0);
        send_update(rand_update());
        drain();
        write_reg(CFG_VEL_P_GAIN, 65536);
        write_reg(CFG_VEL_I_GAIN, 32'h0002_0000);
        write_reg(CFG_INT_STEP, 32'h0001_FFFF);
        write_reg(CFG_MAX_LATERAL, 0);
        send_update(dir_stim[5]);
        send_update(dir_stim[1]);
        drain();
        write_reg(CFG_INT_LIMIT, 10);
        send_update(dir_stim[6]);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            rx_run = (ph % 3 != 2);
            if (ph > 0)
            begin
                random_settings(ph == 3 || ph == 7);
            end
            for (int n = 0; n < N_RANDOM / 10; n++)
            begin
                send_update(rand_update());
            end
            drain();
        end

        $display("Covered %0d output transactions, %0d with zero norm, over 10 register phases.",
                 n_out, n_zero);
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
